// ===== design/monotone_bucket_priority_queue_top_defines.svh =====
// assertion macros for the bucket priority queue
`ifndef MONOTONE_BUCKET_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define MONOTONE_BUCKET_PRIORITY_QUEUE_TOP_DEFINES_SVH
// implication checked on every clock edge outside reset
`define MBPQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication checked outside reset
`define MBPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== design/mbpq_pkg.sv =====
// shared types and constants of the bucket priority queue
`default_nettype none
package mbpq_pkg;
    localparam int NUM_PRIO = 256;
    localparam int CAPACITY = 1024;
    localparam int PW = $clog2(NUM_PRIO);
    localparam int NW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam logic [LW-1:0] NIL = LW'(CAPACITY);

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_POP = 2'd1;
    localparam logic [1:0] KIND_CONTAINS = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    localparam logic [2:0] ERR_OK = 3'd0;
    localparam logic [2:0] ERR_BELOW = 3'd1;
    localparam logic [2:0] ERR_RANGE = 3'd2;
    localparam logic [2:0] ERR_FULL = 3'd3;
    localparam logic [2:0] ERR_EMPTY = 3'd4;

    typedef struct packed {
        logic [63:0] pop_value;
        logic        found;
        logic        is_empty;
        logic [2:0]  error;
        logic [7:0]  current_prio;
    } result_t;
endpackage
`default_nettype wire

// ===== design/mbpq_ram.sv =====
// generic single-port-write ram with registered read
`default_nettype none
module mbpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== design/monotone_bucket_priority_queue_top.sv =====
// top level: sequencer over bucket head, link, value and live memories
// states to result valid: insert INS, INS2, DONE; pop SCAN over buckets, POP2, FIND, DONE;
//   status and refused items DONE; contains FIND over each node (one node read per cycle), DONE
// a new item is taken only in idle, after the last result is loaded; a result waits in its
//   output register; reset: init pass (free list links, NIL bucket heads, live flags cleared)
//   before the first input transfer; rst_n is asynchronous, active low
`default_nettype none
module monotone_bucket_priority_queue_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // prio[15:0], value[79:16]
    input  wire logic [79:0] s_tdata,
    // kind[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // pop_value[63:0], found[64], is_empty[65], error[68:66], current_prio[76:69], pad
    output logic [79:0]      m_tdata
);
    import mbpq_pkg::*;
    `include "monotone_bucket_priority_queue_top_defines.svh"

    typedef enum logic [7:0] {
        ST_INIT  = 8'b00000001,
        ST_IDLE  = 8'b00000010,
        ST_INS   = 8'b00000100,
        ST_INS2  = 8'b00001000,
        ST_SCAN  = 8'b00010000,
        ST_POP2  = 8'b00100000,
        ST_FIND  = 8'b01000000,
        ST_DONE  = 8'b10000000
    } state_t;

    state_t state_reg;
    logic [1:0]  kind_reg;
    logic [PW-1:0] prio_reg;
    logic [63:0] val_reg;
    logic [LW-1:0] free_head_reg;
    logic [PW-1:0] min_reg;
    logic [LW-1:0] count_reg;
    logic [LW-1:0] ctr_reg;
    logic        hit_reg;
    logic [NW-1:0] node_reg;
    logic [63:0] pop_val_reg;
    logic [2:0]  err_reg;
    result_t     res_reg;
    logic        out_valid_reg;

    // bucket head memory
    logic          bh_we;
    logic [PW-1:0] bh_waddr, bh_raddr;
    logic [LW-1:0] bh_wdata, bh_rdata;
    // link memory
    logic          nx_we;
    logic [NW-1:0] nx_waddr, nx_raddr;
    logic [LW-1:0] nx_wdata, nx_rdata;
    // value memory
    logic          nv_we;
    logic [NW-1:0] nv_raddr;
    logic [63:0]   nv_rdata;
    // live flag memory
    logic          lv_we;
    logic [NW-1:0] lv_waddr, lv_raddr;
    logic          lv_wdata, lv_rdata;

    mbpq_ram #(.WIDTH(LW), .DEPTH(NUM_PRIO)) u_head (
        .clk(clk), .we(bh_we), .waddr(bh_waddr), .wdata(bh_wdata),
        .raddr(bh_raddr), .rdata(bh_rdata)
    );
    mbpq_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_next (
        .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
        .raddr(nx_raddr), .rdata(nx_rdata)
    );
    mbpq_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_value (
        .clk(clk), .we(nv_we), .waddr(free_head_reg[NW-1:0]), .wdata(val_reg),
        .raddr(nv_raddr), .rdata(nv_rdata)
    );
    mbpq_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_live (
        .clk(clk), .we(lv_we), .waddr(lv_waddr), .wdata(lv_wdata),
        .raddr(lv_raddr), .rdata(lv_rdata)
    );

    logic s_fire;
    logic can_out;
    logic out_load;
    assign can_out = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_DONE) && can_out;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = {3'b000, res_reg.current_prio, res_reg.error, res_reg.is_empty,
                      res_reg.found, res_reg.pop_value};

    logic [15:0] in_prio;
    assign in_prio = s_tdata[15:0];

    // bucket walk stops at a nonempty head or at the last bucket
    logic scan_stop;
    assign scan_stop = (bh_rdata != NIL) || (prio_reg == PW'(NUM_PRIO - 1));

    logic [PW:0] min_plus;
    assign min_plus = {1'b0, prio_reg} + 1'b1;

    // decode of an accepted item
    logic [2:0] in_err;
    state_t     in_state;
    always_comb
    begin
        in_err = ERR_OK;
        in_state = ST_DONE;
        unique case (s_tuser)
            KIND_INSERT:
            begin
                if (in_prio < 16'(min_reg))
                    in_err = ERR_BELOW;
                else if (in_prio >= 16'(NUM_PRIO))
                    in_err = ERR_RANGE;
                else if (count_reg == LW'(CAPACITY))
                    in_err = ERR_FULL;
                else
                    in_state = ST_INS;
            end
            KIND_POP:
            begin
                if (count_reg == '0)
                    in_err = ERR_EMPTY;
                else
                    in_state = ST_SCAN;
            end
            KIND_CONTAINS:
            begin
                in_state = ST_FIND;
            end
            KIND_STATUS:
            begin
            end
        endcase
    end

    // memory addressing
    always_comb
    begin
        bh_we = 1'b0;
        bh_waddr = prio_reg;
        bh_wdata = NIL;
        bh_raddr = prio_reg;
        nx_we = 1'b0;
        nx_waddr = node_reg;
        nx_wdata = bh_rdata;
        nx_raddr = free_head_reg[NW-1:0];
        nv_we = 1'b0;
        nv_raddr = node_reg;
        lv_we = 1'b0;
        lv_waddr = node_reg;
        lv_wdata = 1'b0;
        lv_raddr = ctr_reg[NW-1:0];
        unique case (state_reg)
            ST_INIT:
            begin
                nx_we = 1'b1;
                nx_waddr = ctr_reg[NW-1:0];
                nx_wdata = ctr_reg + LW'(1);
                bh_we = 1'b1;
                bh_waddr = ctr_reg[PW-1:0];
                lv_we = 1'b1;
                lv_waddr = ctr_reg[NW-1:0];
            end
            ST_IDLE:
            begin
                // a pop starts its walk at the current minimum
                bh_raddr = (s_tuser == KIND_POP) ? min_reg : in_prio[PW-1:0];
            end
            ST_INS:
            begin
                // bucket head and free link both read now
                nv_we = 1'b1;
            end
            ST_INS2:
            begin
                nx_we = 1'b1;
                nx_waddr = free_head_reg[NW-1:0];
                nx_wdata = bh_rdata;
                bh_we = 1'b1;
                bh_wdata = free_head_reg;
                lv_we = 1'b1;
                lv_waddr = free_head_reg[NW-1:0];
                lv_wdata = 1'b1;
            end
            ST_SCAN:
            begin
                bh_raddr = scan_stop ? prio_reg : min_plus[PW-1:0];
            end
            ST_POP2:
            begin
                nx_raddr = bh_rdata[NW-1:0];
                nv_raddr = bh_rdata[NW-1:0];
            end
            ST_FIND:
            begin
                nv_raddr = ctr_reg[NW-1:0];
                // pop writeback: head = next, node links to old free head, live flag cleared
                if (kind_reg == KIND_POP)
                begin
                    bh_we = 1'b1;
                    bh_wdata = nx_rdata;
                    nx_we = 1'b1;
                    nx_waddr = node_reg;
                    nx_wdata = free_head_reg;
                    lv_we = 1'b1;
                    lv_waddr = node_reg;
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            ctr_reg <= '0;
            free_head_reg <= '0;
            min_reg <= '0;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_INIT:
                begin
                    ctr_reg <= ctr_reg + LW'(1);
                    if (ctr_reg == LW'(CAPACITY - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (s_fire)
                    begin
                        kind_reg <= s_tuser;
                        prio_reg <= (s_tuser == KIND_POP) ? min_reg : in_prio[PW-1:0];
                        val_reg <= s_tdata[79:16];
                        pop_val_reg <= '0;
                        err_reg <= in_err;
                        hit_reg <= 1'b0;
                        ctr_reg <= '0;
                        state_reg <= in_state;
                    end
                end
                ST_INS:
                begin
                    state_reg <= ST_INS2;
                end
                ST_INS2:
                begin
                    free_head_reg <= nx_rdata;
                    count_reg <= count_reg + LW'(1);
                    kind_reg <= KIND_STATUS;
                    state_reg <= ST_DONE;
                end
                ST_SCAN:
                begin
                    // walk buckets up from the minimum, stop at the first nonempty one or the last one
                    if (scan_stop)
                    begin
                        if (bh_rdata == NIL)
                        begin
                            err_reg <= ERR_EMPTY;
                            kind_reg <= KIND_STATUS;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            min_reg <= prio_reg;
                            state_reg <= ST_POP2;
                        end
                    end
                    else
                    begin
                        prio_reg <= min_plus[PW-1:0];
                    end
                end
                ST_POP2:
                begin
                    node_reg <= bh_rdata[NW-1:0];
                    state_reg <= ST_FIND;
                    ctr_reg <= NIL;
                end
                ST_FIND:
                begin
                    if (kind_reg == KIND_POP)
                    begin
                        pop_val_reg <= nv_rdata;
                        free_head_reg <= LW'(node_reg);
                        count_reg <= count_reg - LW'(1);
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        // compare data of the previous read while issuing the next
                        if (ctr_reg != '0 && lv_rdata && nv_rdata == val_reg)
                            hit_reg <= 1'b1;
                        node_reg <= ctr_reg[NW-1:0];
                        ctr_reg <= ctr_reg + LW'(1);
                        if (ctr_reg == LW'(CAPACITY))
                            state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (can_out)
                    begin
                        res_reg.pop_value <= pop_val_reg;
                        res_reg.found <= hit_reg;
                        res_reg.is_empty <= (count_reg == '0);
                        res_reg.error <= err_reg;
                        res_reg.current_prio <= 8'(min_reg);
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `MBPQ_ASSERT_IMP(a_count_range, 1'b1, count_reg <= LW'(CAPACITY), "entry count overflow")
    `MBPQ_ASSERT_IMP(a_free_avail, state_reg == ST_IDLE && count_reg != LW'(CAPACITY),
        free_head_reg != NIL, "free list empty below capacity")
    `MBPQ_ASSERT_NEXT(a_done_emits, state_reg == ST_DONE && can_out, m_tvalid,
        "result not emitted")
    `MBPQ_ASSERT_IMP(a_idle_accept, s_tready, state_reg == ST_IDLE, "ready outside idle")
endmodule
`default_nettype wire
